/* sv/text_console_writer_top_macros.svh */
// Assertion macros for the text console writer.
// Used by text_console_writer_top; expects clk and arst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TXC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define TXC_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* sv/txc_pkg.sv */
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
package txc_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] SPACE_CHAR   = 8'd32;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] RETURN_CHAR  = 8'd13;

	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_RSVD  = 2'd3
	} txc_func_t;

	// Screen memory strobes; address and data travel beside it.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} txc_mem_ctl_t;

	// Result offered by the sequencer to the output register.
	typedef struct packed {
		logic valid;
		logic blank;
	} txc_res_t;

endpackage

/* sv/txc_screen_mem.sv */
// Screen character memory, one port, registered read data.
// Depends on txc_pkg for the strobe struct.
module txc_screen_mem import txc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	localparam int AW     = $clog2(ROWS) + $clog2(COLUMNS)
) (
	input  logic         clk,
	input  txc_mem_ctl_t ctl,
	input  logic [AW-1:0] addr,
	input  logic [7:0]   wdata,
	output logic [7:0]   rdata
);

	localparam int DEPTH = ROWS * (2 ** $clog2(COLUMNS));

	logic [7:0] screen_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			screen_q[addr] <= wdata;
		end
		// hold read data until the next read
		if (ctl.rd_en) begin
			rdata_q <= screen_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/txc_ctrl.sv */
// Sequencer for the text console: cursor, scroll offset, row valid bits,
// row fill sweep and the shared column incrementer. Depends on txc_pkg.
module txc_ctrl import txc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	localparam int CW     = $clog2(COLUMNS),
	localparam int RW     = $clog2(ROWS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      func,
	input  logic [7:0]      char_code,
	input  logic [4:0]      read_row,
	input  logic [6:0]      read_col,
	output txc_mem_ctl_t    mem_ctl,
	output logic [RW+CW-1:0] mem_addr,
	output logic [7:0]      mem_wdata,
	output txc_res_t        res,
	input  logic            res_take,
	output logic [CW-1:0]   cur_col,
	output logic [RW-1:0]   cur_row
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_FILL = 5'b00100,
		ST_READ = 5'b01000,
		ST_DONE = 5'b10000
	} txc_state_t;

	txc_state_t state_q;
	txc_func_t  func_q;
	logic [7:0]    char_q;
	logic [RW-1:0] rd_row_q;
	logic [CW-1:0] rd_col_q;
	logic [CW-1:0] fill_col_q;
	logic          rd_blank_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] line_q;
	logic [RW-1:0] top_q;
	logic [ROWS-1:0] row_valid_q;

	logic [RW-1:0] row_sel;
	logic [RW:0]   phys_sum;
	logic [RW:0]   phys_wide;
	logic [RW-1:0] phys;
	logic [CW-1:0] inc_op;
	logic          inc_last;
	logic [CW-1:0] inc_next;
	logic [CW-1:0] mem_col;
	logic          is_ctl;
	logic          row_ok;
	logic [31:0]   rr_sat;
	logic [31:0]   rc_sat;
	logic          top_last;
	logic          line_last;

	// Screen row to physical row: one add, one compare and subtract.
	assign row_sel   = (state_q == ST_READ) ? rd_row_q : line_q;
	assign phys_sum  = {1'b0, row_sel} + {1'b0, top_q};
	assign phys_wide = (phys_sum >= (RW+1)'(ROWS)) ? phys_sum - (RW+1)'(ROWS) : phys_sum;
	assign phys      = phys_wide[RW-1:0];
	assign row_ok    = row_valid_q[phys];

	// Shared column incrementer: fill sweep or cursor advance.
	assign inc_op   = (state_q == ST_FILL) ? fill_col_q : col_q;
	assign inc_last = (inc_op == CW'(COLUMNS - 1));
	assign inc_next = inc_last ? '0 : inc_op + 1'b1;

	assign top_last  = (top_q == RW'(ROWS - 1));
	assign line_last = (line_q == RW'(ROWS - 1));
	assign is_ctl    = (char_q == NEWLINE_CHAR) || (char_q == RETURN_CHAR);

	always_comb begin
		unique case (state_q)
			ST_FILL: mem_col = fill_col_q;
			ST_READ: mem_col = rd_col_q;
			default: mem_col = col_q;
		endcase
	end

	assign mem_addr      = {phys, mem_col};
	assign mem_wdata     = (state_q == ST_FILL) ? SPACE_CHAR : char_q;
	assign mem_ctl.wr_en = (state_q == ST_FILL) ||
		((state_q == ST_EXEC) && (func_q == FUNC_PUT) && !is_ctl && row_ok);
	assign mem_ctl.rd_en = (state_q == ST_READ);

	// Saturate the read position to the screen.
	assign rr_sat = (32'(read_row) >= 32'(ROWS)) ? 32'(ROWS - 1) : 32'(read_row);
	assign rc_sat = (32'(read_col) >= 32'(COLUMNS)) ? 32'(COLUMNS - 1) : 32'(read_col);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q   <= txc_func_t'(func);
			char_q   <= char_code;
			rd_row_q <= rr_sat[RW-1:0];
			rd_col_q <= rc_sat[CW-1:0];
		end
		if (state_q == ST_EXEC) begin
			fill_col_q <= '0;
		end else if (state_q == ST_FILL) begin
			fill_col_q <= inc_next;
		end
		if (state_q == ST_READ) begin
			rd_blank_q <= !row_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			line_q      <= '0;
			top_q       <= '0;
			row_valid_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (func_q)
						FUNC_PUT: begin
							if (!is_ctl && !row_ok) begin
								// fresh row: blank it before the first write
								state_q <= ST_FILL;
							end else begin
								state_q <= ST_READ;
								if (char_q == NEWLINE_CHAR || char_q == RETURN_CHAR) begin
									col_q <= '0;
								end else begin
									col_q <= inc_next;
								end
								if (char_q == NEWLINE_CHAR || (!is_ctl && inc_last)) begin
									if (line_last) begin
										// scroll: old top row becomes the blank bottom row
										row_valid_q[top_q] <= 1'b0;
										top_q <= top_last ? '0 : top_q + 1'b1;
									end else begin
										line_q <= line_q + 1'b1;
									end
								end
							end
						end
						FUNC_CLEAR: begin
							row_valid_q <= '0;
							col_q       <= '0;
							line_q      <= '0;
							top_q       <= '0;
							state_q     <= ST_READ;
						end
						default: begin
							state_q <= ST_READ;
						end
					endcase
				end
				ST_FILL: begin
					if (inc_last) begin
						row_valid_q[phys] <= 1'b1;
						state_q <= ST_EXEC;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_DONE);
	assign res.blank = rd_blank_q;
	assign cur_col   = col_q;
	assign cur_row   = line_q;

endmodule

/* sv/text_console_writer_top.sv */
// Text console writer: character-cell screen with cursor and scrolling.
// Input channel: func, char_code, read_row, read_col under in_valid/in_ready.
// Output channel: cell_char, cursor_col, cursor_row under out_valid/out_ready,
// one result per input transfer, in order.
// An item passes from transfer to result through accept, execute, memory
// read and result. A character landing on a row that is still blank after
// reset, clear or scroll first sweeps that row with spaces through the
// single memory port, and is written after the sweep.
// in_ready is high only while no item is in work.
// Reset blanks the screen at once through per-row valid bits and homes the
// cursor; no clearing pass is needed. If the receiver stalls, the result
// is held in the output register; the next item is still accepted and
// worked on, and waits to load until the register is free.
// Depends on txc_pkg, txc_ctrl, txc_screen_mem and the macros header.
`include "text_console_writer_top_macros.svh"

module text_console_writer_top import txc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_char,
	output logic [6:0] cursor_col,
	output logic [4:0] cursor_row
);

	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	txc_mem_ctl_t    mem_ctl;
	logic [RW+CW-1:0] mem_addr;
	logic [7:0]      mem_wdata;
	logic [7:0]      mem_rdata;
	txc_res_t        res;
	logic            res_take;
	logic [CW-1:0]   cur_col;
	logic [RW-1:0]   cur_row;
	logic [31:0]     col_ext;
	logic [31:0]     row_ext;

	logic       out_valid_q;
	logic [7:0] cell_q;
	logic [6:0] col_out_q;
	logic [4:0] row_out_q;

	txc_ctrl #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.res       (res),
		.res_take  (res_take),
		.cur_col   (cur_col),
		.cur_row   (cur_row)
	);

	txc_screen_mem #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign res_take = !out_valid_q || out_ready;
	assign col_ext  = 32'(cur_col);
	assign row_ext  = 32'(cur_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_take) begin
			// rows never written since reset, clear or scroll read as spaces
			cell_q    <= res.blank ? SPACE_CHAR : mem_rdata;
			col_out_q <= col_ext[6:0];
			row_out_q <= row_ext[4:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_char  = cell_q;
	assign cursor_col = col_out_q;
	assign cursor_row = row_out_q;

	`TXC_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after transfer")
	`TXC_ASSERT(a_cursor_col_range, col_ext < 32'(COLUMNS), "cursor column off screen")
	`TXC_ASSERT(a_cursor_row_range, row_ext < 32'(ROWS), "cursor row off screen")
	`TXC_ASSERT_NEXT(a_result_loaded, res.valid && res_take, out_valid && in_ready, "result lost")

endmodule
